/* hdl/battery_charge_and_gauge_monitor_core_defines.svh */
// Assertion macros shared by the gauge monitor RTL.
`ifndef BATTERY_CHARGE_AND_GAUGE_MONITOR_CORE_DEFINES_SVH
`define BATTERY_CHARGE_AND_GAUGE_MONITOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCGM_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BCGM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bcgm_pkg.sv */
package bcgm_pkg;

    // Item kinds.
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_POLL   = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAMPLE_LIMIT   = 2'd1;
    localparam logic [CFG_DATA_W-1:0]  DEBOUNCE_LIMIT_RST = 8'd2;
    localparam logic [CFG_DATA_W-1:0]  SAMPLE_LIMIT_RST   = 8'd10;
    localparam logic [CFG_DATA_W-1:0]  COUNT_MAX          = 8'd255;

    localparam logic [6:0] PCT_MAX = 7'd100;

    // Datapath widths of the shared adder and the interpolation product.
    localparam int ALU_W  = 24;
    localparam int PROD_W = 23;

    typedef struct packed {
        logic [1:0]  kind;
        logic        curve_select;
        logic [3:0]  point_index;
        logic [15:0] point_voltage;
        logic [6:0]  point_percent;
        logic        charging_now;
        logic        full_now;
        logic [15:0] sample_mv;
    } bcgm_in_t;

    typedef struct packed {
        logic        charge_event;
        logic        charging_state;
        logic        full_state;
        logic [6:0]  percent_level;
        logic [15:0] voltage_level;
        logic        stop_charge_poll;
        logic        stop_sampling;
    } bcgm_out_t;

    // One curve point as held in the curve memory.
    typedef struct packed {
        logic [15:0] volt;
        logic [6:0]  pct;
    } bcgm_point_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } bcgm_alu_op_t;

    typedef struct packed {
        bcgm_alu_op_t     op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } bcgm_alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] result;
        logic             borrow;
    } bcgm_alu_res_t;

endpackage

/* hdl/bcgm_in_if.sv */
interface bcgm_in_if import bcgm_pkg::*; ();
    logic     valid;
    logic     ready;
    bcgm_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/bcgm_out_if.sv */
interface bcgm_out_if import bcgm_pkg::*; ();
    logic      valid;
    logic      ready;
    bcgm_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/battery_charge_and_gauge_monitor_core.sv */
// Battery charge debouncer and voltage-to-percent gauge.
// Items arrive on the item channel and each one gives exactly one beat on the
// report channel. A load item writes one (voltage, percent) point of the
// discharge or charge curve, a poll item updates the debounced charging state,
// and a sample item walks the curve chosen by that state and interpolates.
// Two limits are written on the cfg_we / cfg_index / cfg_data port; the user
// is to write them only while idle, which the block does not enforce. Loads,
// polls and unknown kinds go straight to the done state. A sample walks the
// curve one point a cycle through the registered read port of the curve memory,
// then forms the segment deltas, one multiply, a rounding add and a seven-step
// restoring divide, all but the multiply on one shared adder. One item is
// worked on at a time; item.ready is high whenever the sequencer is idle.
// The report sits in an output register, so a stalled receiver does not stop
// the next item being taken; the sequencer only waits to load that register.
// Reset restores both limits and clears all control state; the curve store is
// cleared at once by a valid bit per entry, so there is no clearing pass.
module battery_charge_and_gauge_monitor_core import bcgm_pkg::*; #(
    parameter int CURVE_POINTS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    bcgm_in_if.sink                item,
    bcgm_out_if.source             report
);

`include "battery_charge_and_gauge_monitor_core_defines.svh"

    localparam int DEPTH = 2 * CURVE_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(CURVE_POINTS);
    localparam int WSUM  = AW + 4;

    localparam logic [PW-1:0] LAST_POINT = PW'(CURVE_POINTS - 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_FIRST = 10'b0000000010,
        S_WALK  = 10'b0000000100,
        S_SEG   = 10'b0000001000,
        S_DX    = 10'b0000010000,
        S_MUL   = 10'b0000100000,
        S_ADD   = 10'b0001000000,
        S_DIV   = 10'b0010000000,
        S_FIN   = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    function automatic logic [6:0] clamp_pct(input logic [6:0] pct);
        return (pct > PCT_MAX) ? PCT_MAX : pct;
    endfunction

    // Control state.
    state_t          state_reg, state_next;
    logic [7:0]      deb_limit_reg, deb_limit_next;
    logic [7:0]      smp_limit_reg, smp_limit_next;
    logic            charging_reg, charging_next;
    logic            full_reg, full_next;
    logic [7:0]      deb_count_reg, deb_count_next;
    logic [7:0]      smp_count_reg, smp_count_next;
    logic [6:0]      percent_reg, percent_next;
    logic [15:0]     voltage_reg, voltage_next;
    logic            ev_reg, ev_next;
    logic            stop_poll_reg, stop_poll_next;
    logic            stop_smp_reg, stop_smp_next;
    logic            out_valid_reg, out_valid_next;
    logic [DEPTH-1:0] valid_reg, valid_next;
    logic            rd_valid_reg;
    logic [PW-1:0]   idx_reg, idx_next;
    logic [2:0]      k_reg, k_next;

    // Datapath registers.
    bcgm_point_t      e0_reg, e0_next;
    bcgm_point_t      e1_reg, e1_next;
    logic [15:0]      dv_reg, dv_next;
    logic [15:0]      dx_reg, dx_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    logic [ALU_W-1:0] rem_reg, rem_next;
    logic [6:0]       q_reg, q_next;
    bcgm_out_t        out_reg, out_next;

    logic             accept;
    logic             load_out;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [WSUM-1:0]  wr_sum;
    logic [AW-1:0]    ram_raddr;
    logic [AW:0]      rd_sum;
    logic [PW-1:0]    rd_idx;
    bcgm_point_t      ram_wdata;
    bcgm_point_t      ram_rdata;
    bcgm_point_t      cur_pt;
    logic             up;
    logic [6:0]       dp;
    logic [6:0]       fin_pct;
    logic [ALU_W-1:0] div_bound;
    bcgm_alu_req_t    alu_req;
    bcgm_alu_res_t    alu_res;

    assign accept       = item.valid && item.ready;
    assign item.ready   = (state_reg == S_IDLE);
    assign report.valid = out_valid_reg;
    assign report.data  = out_reg;
    assign load_out     = (state_reg == S_DONE) && (!out_valid_reg || report.ready);

    // Curve memory write: one point per load beat, indexes past the curve dropped.
    assign wr_sum    = (item.data.curve_select ? WSUM'(CURVE_POINTS) : '0)
                       + WSUM'(item.data.point_index);
    assign ram_waddr = wr_sum[AW-1:0];
    assign ram_we    = accept && (item.data.kind == KIND_LOAD)
                       && (WSUM'(item.data.point_index) < WSUM'(CURVE_POINTS));
    assign ram_wdata = '{volt: item.data.point_voltage, pct: item.data.point_percent};

    // Read address runs one point ahead of the point under test.
    always_comb
    begin
        priority if (state_reg == S_FIRST)
        begin
            rd_idx = PW'(1);
        end
        else if (state_reg == S_WALK)
        begin
            rd_idx = (idx_reg == LAST_POINT) ? idx_reg : idx_reg + PW'(1);
        end
        else
        begin
            rd_idx = '0;
        end
    end

    assign rd_sum    = (charging_reg ? (AW + 1)'(CURVE_POINTS) : '0) + (AW + 1)'(rd_idx);
    assign ram_raddr = rd_sum[AW-1:0];

    bcgm_ram #(
        .WIDTH ($bits(bcgm_point_t)),
        .DEPTH (DEPTH)
    ) u_curve_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // An entry never written since reset reads as zero.
    assign cur_pt = rd_valid_reg ? ram_rdata : '0;

    // Segment slope sign and magnitude of the percent step.
    assign up      = (e1_reg.pct >= e0_reg.pct);
    assign dp      = up ? (e1_reg.pct - e0_reg.pct) : (e0_reg.pct - e1_reg.pct);
    assign fin_pct = up ? (e0_reg.pct + q_reg) : (e0_reg.pct - q_reg);

    // Operand selection for the shared adder.
    always_comb
    begin
        alu_req = '{op: ALU_ADD, a: '0, b: '0};
        unique case (state_reg)
            S_SEG:
            begin
                alu_req = '{op: ALU_SUB, a: ALU_W'(e1_reg.volt), b: ALU_W'(e0_reg.volt)};
            end
            S_DX:
            begin
                alu_req = '{op: ALU_SUB, a: ALU_W'(voltage_reg), b: ALU_W'(e0_reg.volt)};
            end
            S_ADD:
            begin
                alu_req = '{op: ALU_ADD, a: ALU_W'(prod_reg), b: ALU_W'(dv_reg >> 1)};
            end
            S_DIV:
            begin
                alu_req = '{op: ALU_SUB, a: rem_reg, b: ALU_W'(dv_reg) << k_reg};
            end
            default:
            begin
                alu_req = '{op: ALU_ADD, a: '0, b: '0};
            end
        endcase
    end

    bcgm_alu u_alu (
        .req (alu_req),
        .res (alu_res)
    );

    // Sequencer and state update.
    always_comb
    begin
        state_next     = state_reg;
        deb_limit_next = deb_limit_reg;
        smp_limit_next = smp_limit_reg;
        charging_next  = charging_reg;
        full_next      = full_reg;
        deb_count_next = deb_count_reg;
        smp_count_next = smp_count_reg;
        percent_next   = percent_reg;
        voltage_next   = voltage_reg;
        ev_next        = ev_reg;
        stop_poll_next = stop_poll_reg;
        stop_smp_next  = stop_smp_reg;
        valid_next     = valid_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        e0_next        = e0_reg;
        e1_next        = e1_reg;
        dv_next        = dv_reg;
        dx_next        = dx_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;

        if (cfg_we)
        begin
            if (cfg_index == CFG_DEBOUNCE_LIMIT)
            begin
                deb_limit_next = cfg_data;
            end
            else if (cfg_index == CFG_SAMPLE_LIMIT)
            begin
                smp_limit_next = cfg_data;
            end
        end

        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ev_next        = 1'b0;
                    stop_poll_next = 1'b0;
                    stop_smp_next  = 1'b0;
                    state_next     = S_DONE;
                    if (item.data.kind == KIND_POLL)
                    begin
                        if (charging_reg == item.data.charging_now)
                        begin
                            ev_next = item.data.charging_now;
                        end
                        else if (item.data.charging_now)
                        begin
                            charging_next  = 1'b1;
                            deb_count_next = '0;
                            full_next      = item.data.full_now;
                        end
                        else if (deb_count_reg > deb_limit_reg)
                        begin
                            charging_next  = 1'b0;
                            deb_count_next = '0;
                            full_next      = item.data.full_now;
                            stop_poll_next = 1'b1;
                        end
                        else if (deb_count_reg < COUNT_MAX)
                        begin
                            deb_count_next = deb_count_reg + 8'd1;
                        end
                    end
                    else if (item.data.kind == KIND_SAMPLE)
                    begin
                        voltage_next = item.data.sample_mv;
                        state_next   = S_FIRST;
                        if (smp_count_reg > smp_limit_reg)
                        begin
                            smp_count_next = '0;
                            stop_smp_next  = 1'b1;
                        end
                        else if (smp_count_reg < COUNT_MAX)
                        begin
                            smp_count_next = smp_count_reg + 8'd1;
                        end
                    end
                end
            end
            S_FIRST:
            begin
                // An empty curve keeps the old percent.
                if (cur_pt.volt == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    e0_next    = cur_pt;
                    idx_next   = PW'(1);
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                priority if (cur_pt.volt == '0)
                begin
                    state_next = S_DONE;
                end
                else if (cur_pt.volt < voltage_reg)
                begin
                    // Above this point: move on, or keep the percent past the end.
                    if (idx_reg == LAST_POINT)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        e0_next  = cur_pt;
                        idx_next = idx_reg + PW'(1);
                    end
                end
                else
                begin
                    e1_next    = cur_pt;
                    state_next = S_SEG;
                end
            end
            S_SEG:
            begin
                // At or below the segment start the percent saturates to it.
                if (voltage_reg <= e0_reg.volt)
                begin
                    percent_next = clamp_pct(e0_reg.pct);
                    state_next   = S_DONE;
                end
                else
                begin
                    dv_next    = alu_res.result[15:0];
                    state_next = S_DX;
                end
            end
            S_DX:
            begin
                dx_next    = alu_res.result[15:0];
                state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next  = PROD_W'(dx_reg) * PROD_W'(dp);
                state_next = S_ADD;
            end
            S_ADD:
            begin
                rem_next   = alu_res.result;
                q_next     = '0;
                k_next     = 3'd6;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // Restoring divide, one quotient bit a cycle from the top.
                if (!alu_res.borrow)
                begin
                    rem_next        = alu_res.result;
                    q_next[k_reg]   = 1'b1;
                end
                if (k_reg == 3'd0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    k_next = k_reg - 3'd1;
                end
            end
            S_FIN:
            begin
                percent_next = clamp_pct(fin_pct);
                state_next   = S_DONE;
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Report register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (report.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_next       = '{charge_event:     ev_reg,
                               charging_state:   charging_reg,
                               full_state:       full_reg,
                               percent_level:    percent_reg,
                               voltage_level:    voltage_reg,
                               stop_charge_poll: stop_poll_reg,
                               stop_sampling:    stop_smp_reg};
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            deb_limit_reg <= DEBOUNCE_LIMIT_RST;
            smp_limit_reg <= SAMPLE_LIMIT_RST;
            charging_reg  <= 1'b0;
            full_reg      <= 1'b0;
            deb_count_reg <= '0;
            smp_count_reg <= '0;
            percent_reg   <= '0;
            voltage_reg   <= '0;
            ev_reg        <= 1'b0;
            stop_poll_reg <= 1'b0;
            stop_smp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            idx_reg       <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            deb_limit_reg <= deb_limit_next;
            smp_limit_reg <= smp_limit_next;
            charging_reg  <= charging_next;
            full_reg      <= full_next;
            deb_count_reg <= deb_count_next;
            smp_count_reg <= smp_count_next;
            percent_reg   <= percent_next;
            voltage_reg   <= voltage_next;
            ev_reg        <= ev_next;
            stop_poll_reg <= stop_poll_next;
            stop_smp_reg  <= stop_smp_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            rd_valid_reg  <= valid_reg[ram_raddr];
            idx_reg       <= idx_next;
            k_reg         <= k_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        e0_reg   <= e0_next;
        e1_reg   <= e1_next;
        dv_reg   <= dv_next;
        dx_reg   <= dx_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        out_reg  <= out_next;
    end

    // Remainder bound that the divider must keep at every step.
    assign div_bound = ALU_W'(dv_reg) << ({1'b0, k_reg} + 4'd1);

    `BCGM_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, accept, !item.ready,
        "item taken while a previous one is still in progress")
    `BCGM_ASSERT_HOLDS(a_div_rem_bound, clk, rst_n, state_reg == S_DIV, rem_reg < div_bound,
        "divider remainder out of range")
    `BCGM_ASSERT_HOLDS(a_quot_le_step, clk, rst_n, state_reg == S_FIN, q_reg <= dp,
        "interpolation step exceeds segment percent span")
    `BCGM_ASSERT_HOLDS(a_percent_clamped, clk, rst_n, 1'b1, percent_reg <= PCT_MAX,
        "percent estimate above full scale")

endmodule

/* hdl/bcgm_ram.sv */
module bcgm_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/bcgm_alu.sv */
module bcgm_alu import bcgm_pkg::*; (
    input  bcgm_alu_req_t req,
    output bcgm_alu_res_t res
);

    logic [ALU_W-1:0] b_eff;
    logic [ALU_W:0]   total;

    // Add, or subtract by adding the complement with a carry in.
    assign b_eff = (req.op == ALU_SUB) ? ~req.b : req.b;
    assign total = {1'b0, req.a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, req.op == ALU_SUB};

    assign res.result = total[ALU_W-1:0];
    assign res.borrow = (req.op == ALU_SUB) && !total[ALU_W];

endmodule
